### src/tusm_pkg.sv
// Shared constants, controller states and control/status bundles for the matcher.
package tusm_pkg;

  // Default array sizes
  localparam int MaxWomenDef = 32;
  localparam int MaxMenDef   = 32;

  // Summed utility width and the mark left on a rejected pairing
  localparam int UtilW = 18;
  localparam logic signed [UtilW-1:0] Rejected = -18'sd10000;

  // Configuration register indexes
  localparam logic CfgNumWomen = 1'b0;
  localparam logic CfgNumMen   = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_TAIL,
    ST_PROP,
    ST_REJ,
    ST_CHECK,
    ST_OSCAN,
    ST_OTAIL,
    ST_EMIT
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic run_init;    // clear round counter, latch round limit
    logic round_init;  // drop held offers and reject flag
    logic round_inc;
    logic i_clr;
    logic i_inc;
    logic scan_issue;  // read one row entry, advance column
    logic prop;        // record proposal of current woman
    logic rej;         // reject step for current woman
    logic emit;        // drive one result beat
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic j_last;
    logic i_last;
    logic cont;
  } status_t;

endpackage

### src/tusm_dp.sv
// Datapath: utility memory, row scanner, held offers, proposals and result register.
module tusm_dp #(
  parameter int MAX_WOMEN = tusm_pkg::MaxWomenDef,
  parameter int MAX_MEN   = tusm_pkg::MaxMenDef
) (
  input  logic                clk,
  input  logic                rst_n,
  input  tusm_pkg::cmd_t      cmd,
  output tusm_pkg::status_t   status,
  input  logic                load_en,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [5:0]          cfg_data,
  input  logic [4:0]          in_woman,
  input  logic [4:0]          in_man,
  input  logic signed [15:0]  in_woman_utility,
  input  logic signed [15:0]  in_man_utility,
  output logic                out_valid,
  output logic [4:0]          out_woman_out,
  output logic [5:0]          out_partner,
  output logic                out_last_result
);

  localparam int IW  = $clog2(MAX_WOMEN);
  localparam int MW  = $clog2(MAX_MEN);
  localparam int NWW = $clog2(MAX_WOMEN + 1);
  localparam int NMW = $clog2(MAX_MEN + 1);
  localparam int AW  = IW + MW;
  localparam int LW  = NWW + NMW;
  localparam int UW  = tusm_pkg::UtilW;

  // Configuration registers
  logic [5:0] num_women_r, num_men_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_women_r <= 6'd32;
      num_men_r   <= 6'd32;
    end else if (cfg_we) begin
      case (cfg_index)
        tusm_pkg::CfgNumWomen: num_women_r <= cfg_data;
        tusm_pkg::CfgNumMen:   num_men_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Counts in use, saturated to 1..MAX
  logic [NWW-1:0] nw;
  logic [NMW-1:0] nm;

  always_comb begin
    if (num_women_r == 6'd0) nw = NWW'(1);
    else if (int'(num_women_r) > MAX_WOMEN) nw = NWW'(MAX_WOMEN);
    else nw = NWW'(num_women_r);
    if (num_men_r == 6'd0) nm = NMW'(1);
    else if (int'(num_men_r) > MAX_MEN) nm = NMW'(MAX_MEN);
    else nm = NMW'(num_men_r);
  end

  // Woman and column counters
  logic [IW-1:0] i_r;
  logic [MW-1:0] j_r;

  assign status.i_last = (NWW'(i_r) == nw - NWW'(1));
  assign status.j_last = (NMW'(j_r) == nm - NMW'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      i_r <= '0;
      j_r <= '0;
    end else begin
      if (cmd.i_clr) i_r <= '0;
      else if (cmd.i_inc) i_r <= i_r + IW'(1);
      if (cmd.scan_issue) j_r <= status.j_last ? '0 : j_r + MW'(1);
    end
  end

  // Round counting
  logic [LW-1:0] limit_r, round_r, round_inc;
  logic          any_rej_r;
  logic          rej_hit;

  assign round_inc   = round_r + LW'(1);
  assign status.cont = any_rej_r && (round_inc < limit_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r   <= '0;
      round_r   <= '0;
      any_rej_r <= 1'b0;
    end else begin
      if (cmd.run_init) begin
        limit_r <= LW'(nw * nm);
        round_r <= '0;
      end else if (cmd.round_inc) begin
        round_r <= round_inc;
      end
      if (cmd.round_init) any_rej_r <= 1'b0;
      else if (rej_hit) any_rej_r <= 1'b1;
    end
  end

  // Held offers per man and proposals per woman
  logic                 hvalid_r [MAX_MEN];
  logic signed [UW-1:0] hv_r     [MAX_MEN];
  logic                 tvalid_r [MAX_WOMEN];
  logic [MW-1:0]        tidx_r   [MAX_WOMEN];
  logic signed [UW-1:0] pval_r   [MAX_WOMEN];
  logic [MW-1:0]        t_sel;
  logic signed [UW-1:0] eff_hold;

  // Utility memory: one write port, one registered read port
  logic signed [UW-1:0] mem [2**AW];
  logic signed [UW-1:0] rd_data_r;
  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  logic signed [UW-1:0] wr_data;
  logic                 load_ok;

  assign load_ok = load_en && (int'(in_woman) < MAX_WOMEN) && (int'(in_man) < MAX_MEN);

  always_comb begin
    if (load_ok) begin
      wr_en   = 1'b1;
      wr_addr = {IW'(in_woman), MW'(in_man)};
      wr_data = UW'(in_woman_utility) + UW'(in_man_utility);
    end else begin
      wr_en   = rej_hit;
      wr_addr = {i_r, tidx_r[i_r]};
      wr_data = tusm_pkg::Rejected;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data_r <= mem[{i_r, j_r}];
  end

  // Row scan: first column at the row maximum
  logic                 rd_vld_r;
  logic [MW-1:0]        jd_r;
  logic signed [UW-1:0] best_val_r;
  logic [MW-1:0]        best_idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) rd_vld_r <= 1'b0;
    else rd_vld_r <= cmd.scan_issue;
  end

  always_ff @(posedge clk) begin
    jd_r <= j_r;
    if (rd_vld_r && (jd_r == '0 || rd_data_r > best_val_r)) begin
      best_val_r <= rd_data_r;
      best_idx_r <= jd_r;
    end
  end

  // Offer bookkeeping and the reject decision
  assign t_sel    = tidx_r[i_r];
  assign eff_hold = (hvalid_r[t_sel] && hv_r[t_sel] > 0) ? hv_r[t_sel] : '0;
  assign rej_hit  = cmd.rej && tvalid_r[i_r] && (pval_r[i_r] < eff_hold);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int m = 0; m < MAX_MEN; m++) hvalid_r[m] <= 1'b0;
      for (int w = 0; w < MAX_WOMEN; w++) tvalid_r[w] <= 1'b0;
    end else if (cmd.round_init) begin
      for (int m = 0; m < MAX_MEN; m++) hvalid_r[m] <= 1'b0;
    end else if (cmd.prop) begin
      if (!best_val_r[UW-1]) begin
        if (!hvalid_r[best_idx_r] || best_val_r > hv_r[best_idx_r]) begin
          hvalid_r[best_idx_r] <= 1'b1;
        end
        tvalid_r[i_r] <= 1'b1;
      end else begin
        tvalid_r[i_r] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.prop && !best_val_r[UW-1]) begin
      if (!hvalid_r[best_idx_r] || best_val_r > hv_r[best_idx_r]) begin
        hv_r[best_idx_r] <= best_val_r;
      end
      tidx_r[i_r] <= best_idx_r;
      pval_r[i_r] <= best_val_r;
    end
  end

  // Result register, one beat per woman
  logic [MW:0] partner_idx;
  logic        out_valid_r;
  logic [4:0]  out_woman_r;
  logic [5:0]  out_partner_r;
  logic        out_last_r;

  assign partner_idx = {1'b0, best_idx_r} + (MW + 1)'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else out_valid_r <= cmd.emit;
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_woman_r   <= 5'(i_r);
      out_partner_r <= best_val_r[UW-1] ? 6'd0 : 6'(partner_idx);
      out_last_r    <= status.i_last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_woman_out   = out_woman_r;
  assign out_partner     = out_partner_r;
  assign out_last_result = out_last_r;

endmodule

### src/tusm_ctrl.sv
// Controller: sequences loading, proposal/rejection rounds and result beats.
module tusm_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                in_last_entry,
  input  tusm_pkg::status_t   status,
  output tusm_pkg::cmd_t      cmd,
  output logic                load_en,
  output logic                busy
);

  tusm_pkg::state_t state_r, state_nxt;
  logic accept;

  assign busy    = (state_r != tusm_pkg::ST_IDLE);
  assign accept  = start && !busy;
  assign load_en = accept;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= tusm_pkg::ST_IDLE;
    else state_r <= state_nxt;
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tusm_pkg::ST_IDLE:  if (accept && in_last_entry) state_nxt = tusm_pkg::ST_SCAN;
      tusm_pkg::ST_SCAN:  if (status.j_last) state_nxt = tusm_pkg::ST_TAIL;
      tusm_pkg::ST_TAIL:  state_nxt = tusm_pkg::ST_PROP;
      tusm_pkg::ST_PROP:  state_nxt = status.i_last ? tusm_pkg::ST_REJ : tusm_pkg::ST_SCAN;
      tusm_pkg::ST_REJ:   if (status.i_last) state_nxt = tusm_pkg::ST_CHECK;
      tusm_pkg::ST_CHECK: state_nxt = status.cont ? tusm_pkg::ST_SCAN : tusm_pkg::ST_OSCAN;
      tusm_pkg::ST_OSCAN: if (status.j_last) state_nxt = tusm_pkg::ST_OTAIL;
      tusm_pkg::ST_OTAIL: state_nxt = tusm_pkg::ST_EMIT;
      tusm_pkg::ST_EMIT:  state_nxt = status.i_last ? tusm_pkg::ST_IDLE : tusm_pkg::ST_OSCAN;
      default:            state_nxt = tusm_pkg::ST_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd = '0;
    case (state_r)
      tusm_pkg::ST_IDLE: begin
        if (accept && in_last_entry) begin
          cmd.run_init   = 1'b1;
          cmd.round_init = 1'b1;
          cmd.i_clr      = 1'b1;
        end
      end
      tusm_pkg::ST_SCAN, tusm_pkg::ST_OSCAN: cmd.scan_issue = 1'b1;
      tusm_pkg::ST_PROP: begin
        cmd.prop  = 1'b1;
        cmd.i_clr = status.i_last;
        cmd.i_inc = !status.i_last;
      end
      tusm_pkg::ST_REJ: begin
        cmd.rej   = 1'b1;
        cmd.i_clr = status.i_last;
        cmd.i_inc = !status.i_last;
      end
      tusm_pkg::ST_CHECK: begin
        cmd.round_init = status.cont;
        cmd.round_inc  = status.cont;
      end
      tusm_pkg::ST_EMIT: begin
        cmd.emit  = 1'b1;
        cmd.i_clr = status.i_last;
        cmd.i_inc = !status.i_last;
      end
      default: ;
    endcase
  end

endmodule

### src/transferable_utility_stable_matching.sv
// Top level of the summed-utility deferred-acceptance matcher.
// Loading takes one pairing per cycle: start with busy low accepts a beat, and
// the summed utility goes to a MAX_WOMEN x MAX_MEN memory. A beat with
// in_last_entry set runs the match: each round scans every woman's row
// through the single registered memory read port, then takes a rejection step
// per woman and one check step; rounds repeat until one rejects nobody or
// num_women * num_men rounds have run. Results follow, one woman per row scan,
// each on the out_ ports for one cycle under out_valid; the receiver cannot
// stall them. busy drops in the cycle that carries the last result beat, so
// the next load may be accepted at the end of that cycle.
module transferable_utility_stable_matching #(
  parameter int MAX_WOMEN = tusm_pkg::MaxWomenDef,
  parameter int MAX_MEN   = tusm_pkg::MaxMenDef
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [4:0]         in_woman,
  input  logic [4:0]         in_man,
  input  logic signed [15:0] in_woman_utility,
  input  logic signed [15:0] in_man_utility,
  input  logic               in_last_entry,
  output logic               out_valid,
  output logic [4:0]         out_woman_out,
  output logic [5:0]         out_partner,
  output logic               out_last_result,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [5:0]         cfg_data
);

  tusm_pkg::cmd_t    cmd;
  tusm_pkg::status_t status;
  logic              load_en;

  tusm_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .in_last_entry (in_last_entry),
    .status        (status),
    .cmd           (cmd),
    .load_en       (load_en),
    .busy          (busy)
  );

  tusm_dp #(
    .MAX_WOMEN (MAX_WOMEN),
    .MAX_MEN   (MAX_MEN)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .status           (status),
    .load_en          (load_en),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_woman         (in_woman),
    .in_man           (in_man),
    .in_woman_utility (in_woman_utility),
    .in_man_utility   (in_man_utility),
    .out_valid        (out_valid),
    .out_woman_out    (out_woman_out),
    .out_partner      (out_partner),
    .out_last_result  (out_last_result)
  );

endmodule

### src/tusm_checker.sv
// Port-level checks for the matcher, bound to the top level.
module tusm_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic in_last_entry,
  input logic out_valid,
  input logic out_last_result
);

  // A plain load beat never starts a match
  a_load_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && !in_last_entry |=> !busy)
    else $error("busy after a load beat without last entry");

  // The final load beat starts a match
  a_last_starts: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_last_entry |=> busy)
    else $error("match did not start after last entry");

  // Only the final result beat may appear once busy has dropped
  a_result_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !busy |-> out_last_result)
    else $error("result beat outside a match run");

  // Nothing follows the final result beat directly
  a_last_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_result |=> !out_valid)
    else $error("result beat right after the final one");

endmodule

bind transferable_utility_stable_matching tusm_checker u_tusm_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .in_last_entry   (in_last_entry),
  .out_valid       (out_valid),
  .out_last_result (out_last_result)
);

### verif/tb_transferable_utility_stable_matching.sv
// Testbench for the summed-utility deferred-acceptance matcher.
module tb_transferable_utility_stable_matching;

  localparam int NW = 32;
  localparam int NM = 32;
  localparam int NoOffer = -100000;
  localparam int RejMark = -10000;

  typedef struct {
    logic [4:0] woman;
    logic [5:0] partner;
    logic       last;
  } pairing_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [4:0] in_woman = '0;
  logic [4:0] in_man = '0;
  logic signed [15:0] in_woman_utility = '0;
  logic signed [15:0] in_man_utility = '0;
  logic in_last_entry = 1'b0;
  logic out_valid;
  logic [4:0] out_woman_out;
  logic [5:0] out_partner;
  logic out_last_result;
  logic cfg_we = 1'b0;
  logic cfg_index = tusm_pkg::CfgNumWomen;
  logic [5:0] cfg_data = '0;

  // Predictor state
  int         sum_util[NW][NM];
  int         target[NW];
  int         keeper[NM];
  int         kept_val[NM];
  logic [5:0] women_reg = 6'd32;
  logic [5:0] men_reg = 6'd32;

  pairing_t partner_q[$];
  int  fail_count = 0;
  int  beats_sent = 0;
  bit  quiet = 1'b0;

  transferable_utility_stable_matching DUT (.*);

  always #5 clk = ~clk;

  function automatic int clamp_dim(logic [5:0] v, int hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  // First column holding the row maximum
  function automatic int best_man(int w, int nm);
    int b;
    b = 0;
    for (int j = 1; j < nm; j++)
      if (sum_util[w][j] > sum_util[w][b]) b = j;
    return b;
  endfunction

  // Rounds of proposals and rejections, then one partner per woman
  task automatic predict_match();
    int nw, nm, rounds, rejects, b, v, w, t;
    pairing_t r;
    nw = clamp_dim(women_reg, NW);
    nm = clamp_dim(men_reg, NM);
    rounds = 0;
    rejects = 1;
    while (rejects != 0 && rounds < nw * nm) begin
      rounds++;
      rejects = 0;
      for (int j = 0; j < nm; j++) begin
        keeper[j] = 0;
        kept_val[j] = NoOffer;
      end
      for (int i = 0; i < nw; i++) begin
        b = best_man(i, nm);
        v = sum_util[i][b];
        if (v >= 0) begin
          if (v > kept_val[b]) begin
            keeper[b] = i;
            kept_val[b] = v;
          end
          target[i] = b + 1;
        end else begin
          target[i] = 0;
        end
      end
      for (int j = 0; j < nm; j++) begin
        w = keeper[j];
        if (kept_val[j] > RejMark && sum_util[w][j] > 0) begin
          kept_val[j] = sum_util[w][j];
          keeper[j] = w + 1;
        end else begin
          kept_val[j] = 0;
          keeper[j] = 0;
        end
      end
      for (int i = 0; i < nw; i++) begin
        t = target[i];
        if (t > 0 && sum_util[i][t-1] < kept_val[t-1]) begin
          sum_util[i][t-1] = RejMark;
          rejects++;
        end
      end
    end
    for (int i = 0; i < nw; i++) begin
      b = best_man(i, nm);
      r.woman = i[4:0];
      r.partner = (sum_util[i][b] < 0) ? 6'd0 : 6'(b + 1);
      r.last = (i + 1 == nw);
      partner_q.push_back(r);
    end
  endtask

  // Send one pairing beat; start stays high unless a gap follows
  task automatic send_pair(int w, int m, int wu, int mu, bit last);
    in_woman <= w[4:0];
    in_man <= m[4:0];
    in_woman_utility <= wu[15:0];
    in_man_utility <= mu[15:0];
    in_last_entry <= last;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    beats_sent++;
    sum_util[w][m] = 32'(signed'(wu[15:0])) + 32'(signed'(mu[15:0]));
    if (last) predict_match();
    if (!quiet && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    while (partner_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_cfg(logic idx, logic [5:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == tusm_pkg::CfgNumWomen) women_reg = val;
    else men_reg = val;
  endtask

  // Mostly small values so ties, zeros and rejections are common
  function automatic int rand_util();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 65535) - 32768;
      1: return ($urandom_range(0, 1)) ? 32767 : -32768;
      default: return int'($urandom_range(0, 12)) - 4;
    endcase
  endfunction

  // Configure, load every pairing in use in shuffled order, last beat matches
  task automatic match_phase(logic [5:0] wreg, logic [5:0] mreg);
    int cells[$];
    int nw, nm, k, tmp;
    drain();
    write_cfg(tusm_pkg::CfgNumWomen, wreg);
    write_cfg(tusm_pkg::CfgNumMen, mreg);
    nw = clamp_dim(wreg, NW);
    nm = clamp_dim(mreg, NM);
    for (int i = 0; i < nw * nm; i++) cells.push_back(i);
    for (int i = cells.size() - 1; i > 0; i--) begin
      k = $urandom_range(0, i);
      tmp = cells[i];
      cells[i] = cells[k];
      cells[k] = tmp;
    end
    foreach (cells[i])
      send_pair(cells[i] / nm, cells[i] % nm, rand_util(), rand_util(),
                i == cells.size() - 1);
  endtask

  // Extremes of the utilities, zero kept values, ties, reruns on the loaded matrix
  task automatic test_directed();
    drain();
    write_cfg(tusm_pkg::CfgNumWomen, 6'd2);
    write_cfg(tusm_pkg::CfgNumMen, 6'd2);
    send_pair(0, 0, 32767, 32767, 0);
    send_pair(0, 1, -32768, -32768, 0);
    send_pair(1, 0, 32767, 32767, 0);
    send_pair(1, 1, 5, -5, 1);
    drain();
    // two women on one man at zero value
    send_pair(0, 0, 0, 0, 0);
    send_pair(0, 1, -1, 0, 0);
    send_pair(1, 0, 3, -3, 0);
    send_pair(1, 1, -7, 2, 1);
    drain();
    // equal rows force tie breaks
    send_pair(0, 0, 4, 4, 0);
    send_pair(0, 1, 4, 4, 0);
    send_pair(1, 0, 4, 4, 0);
    send_pair(1, 1, 4, 4, 1);
    drain();
    // rerun on the matrix left by the previous run
    send_pair(1, 1, 4, 4, 1);
    send_pair(0, 1, 1, 0, 1);
  endtask

  // Out-of-range register values saturate; reach every index bit
  task automatic test_saturation();
    match_phase(6'd0, 6'd63);
    match_phase(6'd63, 6'd0);
    match_phase(6'd1, 6'd1);
  endtask

  task automatic test_random();
    while (beats_sent < 370) begin
      if (beats_sent > 300) quiet = 1'b1;
      match_phase(6'($urandom_range(1, 6)), 6'($urandom_range(1, 6)));
      if ($urandom_range(0, 2) == 0)
        send_pair($urandom_range(0, clamp_dim(women_reg, NW) - 1),
                  $urandom_range(0, clamp_dim(men_reg, NM) - 1),
                  rand_util(), rand_util(), 1);
    end
  endtask

  // Compare each result beat with the oldest expectation
  always @(posedge clk) begin
    pairing_t e;
    if (rst_n && out_valid) begin
      if (partner_q.size() == 0) begin
        $error("unexpected result beat woman_out=%0d", out_woman_out);
        fail_count++;
      end else begin
        e = partner_q.pop_front();
        if (out_woman_out !== e.woman) begin
          $error("woman_out expected %0d got %0d", e.woman, out_woman_out);
          fail_count++;
        end
        if (out_partner !== e.partner) begin
          $error("partner expected %0d got %0d", e.partner, out_partner);
          fail_count++;
        end
        if (out_last_result !== e.last) begin
          $error("last_result expected %0d got %0d", e.last, out_last_result);
          fail_count++;
        end
      end
    end
  end

  initial begin
    for (int i = 0; i < NW; i++)
      for (int j = 0; j < NM; j++) sum_util[i][j] = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_saturation();
    test_random();
    drain();
    repeat (200) @(posedge clk);
    if (fail_count == 0 && partner_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      if (partner_q.size() != 0) $error("%0d results never arrived", partner_q.size());
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("Verification failed");
    $finish;
  end

endmodule

### files.f
src/tusm_pkg.sv
src/tusm_dp.sv
src/tusm_ctrl.sv
src/transferable_utility_stable_matching.sv
src/tusm_checker.sv
verif/tb_transferable_utility_stable_matching.sv
